FILE: rtl/rjp_pkg.sv
// shared types and constants of the rtp/jpeg packetizer
package rjp_pkg;

   // fixed header layout
   localparam int HDR_LEN = 20;
   localparam int HDR_IDX_W = 5;
   localparam logic [HDR_IDX_W-1:0] HDR_DONE = HDR_IDX_W'(HDR_LEN);

   // field values
   localparam logic [7:0] RTP_VERSION_BYTE = 8'h80;
   localparam logic [6:0] RTP_PAYLOAD_TYPE = 7'h1a;
   localparam logic [7:0] DRI_FLAG = 8'h40;
   localparam logic [7:0] TYPE_SPECIFIC = 8'h00;
   localparam logic [10:0] PAYLOAD_CAP = 11'd2028;

   // configuration register indexes
   localparam logic [2:0] CSR_WIDTH_BLOCKS = 3'd0;
   localparam logic [2:0] CSR_HEIGHT_BLOCKS = 3'd1;
   localparam logic [2:0] CSR_JPEG_TYPE = 3'd2;
   localparam logic [2:0] CSR_QUALITY_FACTOR = 3'd3;
   localparam logic [2:0] CSR_DRI_ENABLE = 3'd4;
   localparam logic [2:0] CSR_SOURCE_ID = 3'd5;
   localparam logic [2:0] CSR_MAX_PAYLOAD = 3'd6;

   // reset values of the configuration registers
   localparam logic [7:0] RST_WIDTH_BLOCKS = 8'd8;
   localparam logic [7:0] RST_HEIGHT_BLOCKS = 8'd6;
   localparam logic [7:0] RST_JPEG_TYPE = 8'd1;
   localparam logic [7:0] RST_QUALITY_FACTOR = 8'd84;
   localparam logic [31:0] RST_SOURCE_ID = 32'h13f97e67;
   localparam logic [10:0] RST_MAX_PAYLOAD = 11'd1400;

   typedef struct packed {
      logic [7:0] width_blocks;
      logic [7:0] height_blocks;
      logic [7:0] jpeg_type;
      logic [7:0] quality_factor;
      logic dri_enable;
      logic [31:0] source_id;
      logic [10:0] max_payload;
   } cfg_type;

   // one classified item travelling from front to back
   typedef struct packed {
      logic has_hdr;
      logic marker;
      logic [15:0] seq;
      logic [31:0] stamp;
      logic [23:0] offset;
      logic [7:0] data;
      logic pkt_end;
   } entry_type;

endpackage

FILE: rtl/rjp_front.sv
// front part: frame and packet bookkeeping, classifies each input item
module rjp_front (
   input logic clock,
   input logic reset,
   input rjp_pkg::cfg_type cfg,
   input logic req_valid,
   output logic req_ready,
   input logic [7:0] req_data_byte,
   input logic [23:0] req_frame_length,
   input logic [31:0] req_time_delta,
   output logic push_valid,
   input logic push_ready,
   output rjp_pkg::entry_type push_entry
);

   logic [15:0] seq_ff, seq_in;
   logic [31:0] stamp_ff, stamp_in;
   logic [23:0] remain_ff, remain_in;
   logic [23:0] offset_ff, offset_in;
   logic [10:0] fill_ff, fill_in;

   logic accept;
   logic frame_start;
   logic [10:0] max_pl;
   logic [23:0] flen;
   logic [23:0] remain_cur, remain_nx;
   logic [23:0] offset_cur;
   logic [10:0] fill_cur, fill_nx;
   logic pkt_end;

   assign req_ready = push_ready;
   assign push_valid = req_valid;
   assign accept = req_valid && push_ready;

   // effective payload bound
   always_comb begin
      if (cfg.max_payload == 11'd0) begin
         max_pl = 11'd1;
      end else if (cfg.max_payload > rjp_pkg::PAYLOAD_CAP) begin
         max_pl = rjp_pkg::PAYLOAD_CAP;
      end else begin
         max_pl = cfg.max_payload;
      end
   end

   // frame start picks up the new length
   assign frame_start = (remain_ff == 24'd0);
   assign flen = (req_frame_length == 24'd0) ? 24'd1 : req_frame_length;
   assign remain_cur = frame_start ? flen : remain_ff;
   assign offset_cur = frame_start ? 24'd0 : offset_ff;
   assign fill_cur = frame_start ? 11'd0 : fill_ff;

   assign remain_nx = remain_cur - 24'd1;
   assign fill_nx = fill_cur + 11'd1;
   assign pkt_end = (remain_nx == 24'd0) || (fill_nx >= max_pl);

   // item handed to the back part
   always_comb begin
      push_entry.has_hdr = (fill_cur == 11'd0);
      push_entry.marker = (remain_cur <= {13'd0, max_pl});
      push_entry.seq = seq_ff;
      push_entry.stamp = stamp_ff;
      push_entry.offset = offset_cur;
      push_entry.data = req_data_byte;
      push_entry.pkt_end = pkt_end;
   end

   // state update on an accepted item
   always_comb begin
      seq_in = seq_ff;
      stamp_in = stamp_ff;
      remain_in = remain_ff;
      offset_in = offset_ff;
      fill_in = fill_ff;
      if (accept) begin
         remain_in = remain_nx;
         offset_in = offset_cur + 24'd1;
         fill_in = pkt_end ? 11'd0 : fill_nx;
         if (pkt_end) begin
            seq_in = seq_ff + 16'd1;
         end
         if (pkt_end && (remain_nx == 24'd0)) begin
            stamp_in = stamp_ff + req_time_delta;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff <= '0;
         stamp_ff <= '0;
         remain_ff <= '0;
         offset_ff <= '0;
         fill_ff <= '0;
      end else begin
         seq_ff <= seq_in;
         stamp_ff <= stamp_in;
         remain_ff <= remain_in;
         offset_ff <= offset_in;
         fill_ff <= fill_in;
      end
   end

endmodule

FILE: rtl/rjp_queue.sv
// two-entry queue between the front and back parts
module rjp_queue (
   input logic clock,
   input logic reset,
   input logic push_valid,
   output logic push_ready,
   input rjp_pkg::entry_type push_entry,
   output logic pop_valid,
   input logic pop_ready,
   output rjp_pkg::entry_type pop_entry
);

   rjp_pkg::entry_type slot_ff [2];
   logic wr_ptr_ff, wr_ptr_in;
   logic rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic push, pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_entry = slot_ff[rd_ptr_ff];
   assign push = push_valid && push_ready;
   assign pop = pop_valid && pop_ready;

   // pointer and count update
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // storage, no reset
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

FILE: rtl/rjp_back.sv
// back part: serialises header and payload bytes into the output register
module rjp_back (
   input logic clock,
   input logic reset,
   input rjp_pkg::cfg_type cfg,
   input logic head_valid,
   output logic head_pop,
   input rjp_pkg::entry_type head,
   output logic rsp_valid,
   input logic rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic rsp_packet_end,
   output logic rsp_run_last
);

   logic [rjp_pkg::HDR_IDX_W-1:0] idx_ff, idx_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [7:0] byte_ff, byte_in;
   logic pend_ff, pend_in;
   logic last_ff, last_in;

   logic [7:0] hdr [rjp_pkg::HDR_LEN];
   logic load;
   logic in_hdr;

   // header bytes of the item at the head
   always_comb begin
      hdr[0] = rjp_pkg::RTP_VERSION_BYTE;
      hdr[1] = {head.marker, rjp_pkg::RTP_PAYLOAD_TYPE};
      hdr[2] = head.seq[15:8];
      hdr[3] = head.seq[7:0];
      hdr[4] = head.stamp[31:24];
      hdr[5] = head.stamp[23:16];
      hdr[6] = head.stamp[15:8];
      hdr[7] = head.stamp[7:0];
      hdr[8] = cfg.source_id[31:24];
      hdr[9] = cfg.source_id[23:16];
      hdr[10] = cfg.source_id[15:8];
      hdr[11] = cfg.source_id[7:0];
      hdr[12] = rjp_pkg::TYPE_SPECIFIC;
      hdr[13] = head.offset[23:16];
      hdr[14] = head.offset[15:8];
      hdr[15] = head.offset[7:0];
      hdr[16] = cfg.jpeg_type | (cfg.dri_enable ? rjp_pkg::DRI_FLAG : 8'h00);
      hdr[17] = cfg.quality_factor;
      hdr[18] = cfg.width_blocks;
      hdr[19] = cfg.height_blocks;
   end

   assign load = !rsp_valid_ff || rsp_ready;
   assign in_hdr = head.has_hdr && (idx_ff != rjp_pkg::HDR_DONE);
   assign head_pop = load && head_valid && !in_hdr;

   // next output byte and header position
   always_comb begin
      idx_in = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      byte_in = byte_ff;
      pend_in = pend_ff;
      last_in = last_ff;
      if (load && head_valid) begin
         rsp_valid_in = 1'b1;
         if (in_hdr) begin
            byte_in = hdr[idx_ff];
            pend_in = 1'b0;
            last_in = 1'b0;
            idx_in = idx_ff + rjp_pkg::HDR_IDX_W'(1);
         end else begin
            byte_in = head.data;
            pend_in = head.pkt_end;
            last_in = 1'b1;
            idx_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      byte_ff <= byte_in;
      pend_ff <= pend_in;
      last_ff <= last_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_packet_end = pend_ff;
   assign rsp_run_last = last_ff;

endmodule

FILE: rtl/rtp_jpeg_packetizer.sv
// Top level of the RTP/JPEG packetizer: configuration registers, front, queue, back.
// An accepted item goes into the queue; its first byte is then registered at the output.
// Throughput: one item per cycle unless the output stalls; an item that opens a packet
// holds the output for its 20 header bytes and its data byte, sent by the byte serialiser.
// Reset: synchronous; counters and timestamp clear, registers take their defaults.
module rtp_jpeg_packetizer (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   input logic [7:0] req_data_byte,
   input logic [23:0] req_frame_length,
   input logic [31:0] req_time_delta,
   output logic rsp_valid,
   input logic rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic rsp_packet_end,
   output logic rsp_run_last,
   input logic csr_we,
   input logic [2:0] csr_index,
   input logic [31:0] csr_wdata
);

   rjp_pkg::cfg_type cfg_ff, cfg_in;
   rjp_pkg::entry_type push_entry, head;
   logic push_valid, push_ready;
   logic head_valid, head_pop;

   // configuration register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            rjp_pkg::CSR_WIDTH_BLOCKS: cfg_in.width_blocks = csr_wdata[7:0];
            rjp_pkg::CSR_HEIGHT_BLOCKS: cfg_in.height_blocks = csr_wdata[7:0];
            rjp_pkg::CSR_JPEG_TYPE: cfg_in.jpeg_type = csr_wdata[7:0];
            rjp_pkg::CSR_QUALITY_FACTOR: cfg_in.quality_factor = csr_wdata[7:0];
            rjp_pkg::CSR_DRI_ENABLE: cfg_in.dri_enable = csr_wdata[0];
            rjp_pkg::CSR_SOURCE_ID: cfg_in.source_id = csr_wdata;
            rjp_pkg::CSR_MAX_PAYLOAD: cfg_in.max_payload = csr_wdata[10:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.width_blocks <= rjp_pkg::RST_WIDTH_BLOCKS;
         cfg_ff.height_blocks <= rjp_pkg::RST_HEIGHT_BLOCKS;
         cfg_ff.jpeg_type <= rjp_pkg::RST_JPEG_TYPE;
         cfg_ff.quality_factor <= rjp_pkg::RST_QUALITY_FACTOR;
         cfg_ff.dri_enable <= 1'b0;
         cfg_ff.source_id <= rjp_pkg::RST_SOURCE_ID;
         cfg_ff.max_payload <= rjp_pkg::RST_MAX_PAYLOAD;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: bookkeeping and classification
   rjp_front u_front (
      .clock(clock),
      .reset(reset),
      .cfg(cfg_ff),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data_byte(req_data_byte),
      .req_frame_length(req_frame_length),
      .req_time_delta(req_time_delta),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_entry(push_entry)
   );

   // queue between the two parts
   rjp_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_entry(push_entry),
      .pop_valid(head_valid),
      .pop_ready(head_pop),
      .pop_entry(head)
   );

   // back: byte serialiser
   rjp_back u_back (
      .clock(clock),
      .reset(reset),
      .cfg(cfg_ff),
      .head_valid(head_valid),
      .head_pop(head_pop),
      .head(head),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_out_byte(rsp_out_byte),
      .rsp_packet_end(rsp_packet_end),
      .rsp_run_last(rsp_run_last)
   );

endmodule
